// File: src/tweakable_feistel_block_cipher_unit_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tweakable Feistel block cipher unit
// Expects clk and rst_n in the scope where a macro is used.
// ----------------------------------------------------------------------------
`ifndef TWEAKABLE_FEISTEL_BLOCK_CIPHER_UNIT_MACROS_SVH
`define TWEAKABLE_FEISTEL_BLOCK_CIPHER_UNIT_MACROS_SVH

// same-cycle implication
`define TFBC_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define TFBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/tfbc_pkg.sv
// ----------------------------------------------------------------------------
// tfbc_pkg
// Types, constants and round functions of the tweakable Feistel block cipher.
// ----------------------------------------------------------------------------
package tfbc_pkg;

    localparam int FEISTEL_ROUNDS_DEF = 8;
    localparam int PERM_ROUNDS_DEF    = 6;
    localparam int ASCON_ROUNDS       = 12;
    localparam int PERM_W             = 4;
    localparam int RC_IDX_W           = 6;
    localparam int CFG_IDX_W          = 2;
    localparam int CFG_W              = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HI = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LO = 2'd1;

    localparam logic [7:0] GF_POLY = 8'h87;

    localparam logic [31:0] ROUND_CONST [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FLUSH
    } ctl_state_t;

    typedef struct packed {
        logic                load_item;
        logic                step;
        logic                first_perm;
        logic                last_perm;
        logic [PERM_W-1:0]   perm_idx;
        logic [RC_IDX_W-1:0] rc_idx;
        logic                out_load;
        logic                out_direct;
        logic                sweep_step;
    } ctl_cmd_t;

    typedef struct packed {
        logic dec;
    } dp_status_t;

    typedef struct packed {
        logic [63:0] x0;
        logic [63:0] x1;
        logic [63:0] x2;
        logic [63:0] x3;
        logic [63:0] x4;
    } perm_state_t;

    function automatic logic [63:0] rotr(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic perm_state_t ascon_round(perm_state_t s, logic [PERM_W-1:0] k);
        logic [63:0] x0, x1, x2, x3, x4;
        logic [63:0] t0, t1, t2, t3, t4;
        perm_state_t r;
        x0 = s.x0;
        x1 = s.x1;
        x2 = s.x2;
        x3 = s.x3;
        x4 = s.x4;
        x2 = x2 ^ {56'd0, ~k, k};
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = ~x0 & x1;
        t1 = ~x1 & x2;
        t2 = ~x2 & x3;
        t3 = ~x3 & x4;
        t4 = ~x4 & x0;
        x0 = x0 ^ t1;
        x1 = x1 ^ t2;
        x2 = x2 ^ t3;
        x3 = x3 ^ t4;
        x4 = x4 ^ t0;
        x1 = x1 ^ x0;
        x0 = x0 ^ x4;
        x3 = x3 ^ x2;
        x2 = ~x2;
        r.x0 = x0 ^ rotr(x0, 19) ^ rotr(x0, 28);
        r.x1 = x1 ^ rotr(x1, 61) ^ rotr(x1, 39);
        r.x2 = x2 ^ rotr(x2, 1) ^ rotr(x2, 6);
        r.x3 = x3 ^ rotr(x3, 10) ^ rotr(x3, 17);
        r.x4 = x4 ^ rotr(x4, 7) ^ rotr(x4, 41);
        return r;
    endfunction

    // multiply by x in GF(2^128)
    function automatic logic [127:0] gf_double(logic [127:0] v);
        return {v[126:0], 1'b0} ^ (v[127] ? {120'd0, GF_POLY} : 128'd0);
    endfunction

    // inverse of gf_double: the low bit tells whether the polynomial was folded in
    function automatic logic [127:0] gf_halve(logic [127:0] v);
        logic [127:0] t;
        t = v ^ (v[0] ? {120'd0, GF_POLY} : 128'd0);
        return {v[0], t[127:1]};
    endfunction

endpackage

// File: src/tfbc_datapath.sv
// ----------------------------------------------------------------------------
// tfbc_datapath
// Key registers, round key tracking, Feistel halves, shared Ascon round unit
// and the output register.
// ----------------------------------------------------------------------------
module tfbc_datapath
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tfbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfbc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           op,
    input  logic [63:0]                    data_hi,
    input  logic [63:0]                    data_lo,
    input  logic [63:0]                    tweak_hi,
    input  logic [31:0]                    tweak_lo,
    input  tfbc_pkg::ctl_cmd_t             cmd,
    output tfbc_pkg::dp_status_t           status,
    output logic [63:0]                    out_hi,
    output logic [63:0]                    out_lo
);

    logic [63:0]            key_hi_reg;
    logic [63:0]            key_lo_reg;
    logic [127:0]           key_last_reg;
    logic [127:0]           key_cur_reg;
    logic [63:0]            l_reg;
    logic [63:0]            r_reg;
    logic [63:0]            tw_hi_reg;
    logic [31:0]            tw_lo_reg;
    logic                   dec_reg;
    tfbc_pkg::perm_state_t  x_reg;
    logic [63:0]            out_hi_reg;
    logic [63:0]            out_lo_reg;

    tfbc_pkg::perm_state_t  perm_in;
    tfbc_pkg::perm_state_t  perm_out;
    logic [63:0]            new_r;

    always_comb
    begin
        if (cmd.first_perm)
        begin
            perm_in.x0 = r_reg;
            perm_in.x1 = key_cur_reg[127:64];
            perm_in.x2 = key_cur_reg[63:0];
            perm_in.x3 = tw_hi_reg;
            perm_in.x4 = {tw_lo_reg, tfbc_pkg::ROUND_CONST[cmd.rc_idx]};
        end
        else
        begin
            perm_in = x_reg;
        end
        perm_out = tfbc_pkg::ascon_round(perm_in, cmd.perm_idx);
        new_r    = perm_out.x0 ^ l_reg;
    end

    // key registers and decrypt start key
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_hi_reg   <= '0;
            key_lo_reg   <= '0;
            key_last_reg <= '0;
        end
        else if (cfg_we && cfg_index == tfbc_pkg::REG_KEY_HI)
        begin
            key_hi_reg   <= cfg_data;
            key_last_reg <= {cfg_data, key_lo_reg};
        end
        else if (cfg_we && cfg_index == tfbc_pkg::REG_KEY_LO)
        begin
            key_lo_reg   <= cfg_data;
            key_last_reg <= {key_hi_reg, cfg_data};
        end
        else if (cmd.sweep_step)
        begin
            key_last_reg <= tfbc_pkg::gf_double(key_last_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            l_reg       <= data_hi;
            r_reg       <= data_lo;
            tw_hi_reg   <= tweak_hi;
            tw_lo_reg   <= tweak_lo;
            dec_reg     <= op;
            key_cur_reg <= op ? key_last_reg : {key_hi_reg, key_lo_reg};
        end
        else if (cmd.step)
        begin
            x_reg <= perm_out;
            if (cmd.last_perm)
            begin
                l_reg       <= r_reg;
                r_reg       <= new_r;
                key_cur_reg <= dec_reg ? tfbc_pkg::gf_halve(key_cur_reg)
                                       : tfbc_pkg::gf_double(key_cur_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            if (cmd.out_direct)
            begin
                out_hi_reg <= new_r;
                out_lo_reg <= r_reg;
            end
            else
            begin
                out_hi_reg <= r_reg;
                out_lo_reg <= l_reg;
            end
        end
    end

    assign status.dec = dec_reg;
    assign out_hi     = out_hi_reg;
    assign out_lo     = out_lo_reg;

endmodule

// File: src/tfbc_ctrl.sv
// ----------------------------------------------------------------------------
// tfbc_ctrl
// Sequencer: round counters, key sweep after key writes, handshakes.
// ----------------------------------------------------------------------------
`include "tweakable_feistel_block_cipher_unit_macros.svh"

module tfbc_ctrl
#(
    parameter int FEISTEL_ROUNDS = tfbc_pkg::FEISTEL_ROUNDS_DEF,
    parameter int PERM_ROUNDS    = tfbc_pkg::PERM_ROUNDS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tfbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic                           in_valid,
    output logic                           in_ready,
    output logic                           out_valid,
    input  logic                           out_stall,
    input  tfbc_pkg::dp_status_t           status,
    output tfbc_pkg::ctl_cmd_t             cmd
);

    localparam int RND_W = $clog2(FEISTEL_ROUNDS);
    localparam logic [tfbc_pkg::PERM_W-1:0] PERM_FIRST =
        tfbc_pkg::PERM_W'(tfbc_pkg::ASCON_ROUNDS - PERM_ROUNDS);
    localparam logic [tfbc_pkg::PERM_W-1:0] PERM_LAST =
        tfbc_pkg::PERM_W'(tfbc_pkg::ASCON_ROUNDS - 1);
    localparam logic [RND_W-1:0] RND_LAST = RND_W'(FEISTEL_ROUNDS - 1);

    tfbc_pkg::ctl_state_t state_reg;
    tfbc_pkg::ctl_state_t state_next;

    logic [tfbc_pkg::PERM_W-1:0] perm_reg;
    logic [tfbc_pkg::PERM_W-1:0] perm_next;
    logic [RND_W-1:0]            rnd_reg;
    logic [RND_W-1:0]            rnd_next;
    logic [RND_W-1:0]            sweep_reg;
    logic [RND_W-1:0]            sweep_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    logic key_write;
    logic out_free;
    logic last_perm;
    logic last_rnd;
    logic accept;
    logic [RND_W-1:0] rnd_idx;

    assign key_write = cfg_we && (cfg_index == tfbc_pkg::REG_KEY_HI ||
                                  cfg_index == tfbc_pkg::REG_KEY_LO);
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_perm = perm_reg == PERM_LAST;
    assign last_rnd  = rnd_reg == RND_LAST;
    assign in_ready  = state_reg == tfbc_pkg::ST_IDLE && sweep_reg == '0;
    assign accept    = in_valid && in_ready;
    assign rnd_idx   = status.dec ? RND_LAST - rnd_reg : rnd_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tfbc_pkg::ST_IDLE:
            begin
                if (accept)
                    state_next = tfbc_pkg::ST_RUN;
            end
            tfbc_pkg::ST_RUN:
            begin
                if (last_perm && last_rnd)
                    state_next = out_free ? tfbc_pkg::ST_IDLE : tfbc_pkg::ST_FLUSH;
            end
            tfbc_pkg::ST_FLUSH:
            begin
                if (out_free)
                    state_next = tfbc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = tfbc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        cmd.perm_idx   = perm_reg;
        cmd.rc_idx     = tfbc_pkg::RC_IDX_W'(rnd_idx);
        cmd.first_perm = perm_reg == PERM_FIRST;
        cmd.last_perm  = last_perm;
        cmd.sweep_step = sweep_reg != '0 && !key_write;
        unique case (state_reg)
            tfbc_pkg::ST_IDLE:
            begin
                cmd.load_item = accept;
            end
            tfbc_pkg::ST_RUN:
            begin
                cmd.step       = 1'b1;
                cmd.out_load   = last_perm && last_rnd && out_free;
                cmd.out_direct = 1'b1;
            end
            tfbc_pkg::ST_FLUSH:
            begin
                cmd.out_load = out_free;
            end
            default:
            begin
                cmd.load_item = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        perm_next = perm_reg;
        rnd_next  = rnd_reg;
        if (cmd.load_item)
        begin
            perm_next = PERM_FIRST;
            rnd_next  = '0;
        end
        else if (cmd.step)
        begin
            perm_next = last_perm ? PERM_FIRST : perm_reg + 1'b1;
            if (last_perm)
                rnd_next = last_rnd ? '0 : rnd_reg + 1'b1;
        end

        priority if (key_write)
            sweep_next = RND_LAST;
        else if (sweep_reg != '0)
            sweep_next = sweep_reg - 1'b1;
        else
            sweep_next = sweep_reg;

        priority if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tfbc_pkg::ST_IDLE;
            perm_reg      <= PERM_FIRST;
            rnd_reg       <= '0;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            perm_reg      <= perm_next;
            rnd_reg       <= rnd_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `TFBC_ASSERT_NEXT(a_accept_starts, accept, state_reg == tfbc_pkg::ST_RUN && perm_reg == PERM_FIRST && rnd_reg == '0, "accepted beat did not start the rounds")
    `TFBC_ASSERT_IMPL(a_sweep_blocks, sweep_reg != '0, !in_ready, "input ready during key sweep")
    `TFBC_ASSERT_IMPL(a_no_overwrite, cmd.out_load, !out_valid_reg || !out_stall, "pending result overwritten")
    `TFBC_ASSERT_NEXT(a_flush_on_stall, state_reg == tfbc_pkg::ST_RUN && last_perm && last_rnd && !out_free, state_reg == tfbc_pkg::ST_FLUSH, "finished block lost under stall")

endmodule

// File: src/tweakable_feistel_block_cipher_unit.sv
// ----------------------------------------------------------------------------
// tweakable_feistel_block_cipher_unit
// Tweakable 128-bit Feistel cipher on a reduced-round Ascon permutation.
// ----------------------------------------------------------------------------
// Each block runs one Ascon round per cycle on a single shared round unit. A
// new block is accepted only once the last is loaded into the output register.
// A key write starts a sweep for the decrypt start key; input is stalled during
// it. Reset clears keys to zero and empties the unit.
module tweakable_feistel_block_cipher_unit
#(
    parameter int FEISTEL_ROUNDS = tfbc_pkg::FEISTEL_ROUNDS_DEF,
    parameter int PERM_ROUNDS    = tfbc_pkg::PERM_ROUNDS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tfbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfbc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           op,
    input  logic [63:0]                    data_hi,
    input  logic [63:0]                    data_lo,
    input  logic [63:0]                    tweak_hi,
    input  logic [31:0]                    tweak_lo,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [63:0]                    out_hi,
    output logic [63:0]                    out_lo
);

    tfbc_pkg::ctl_cmd_t   cmd;
    tfbc_pkg::dp_status_t status;
    logic                 in_ready;

    tfbc_ctrl
    #(
        .FEISTEL_ROUNDS (FEISTEL_ROUNDS),
        .PERM_ROUNDS    (PERM_ROUNDS)
    )
    u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tfbc_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .op        (op),
        .data_hi   (data_hi),
        .data_lo   (data_lo),
        .tweak_hi  (tweak_hi),
        .tweak_lo  (tweak_lo),
        .cmd       (cmd),
        .status    (status),
        .out_hi    (out_hi),
        .out_lo    (out_lo)
    );

    assign in_stall = !in_ready;

endmodule

// File: dv/tfbc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tfbc_checker
// Watches the key port and both channels of the tweakable Feistel cipher unit.
// For every accepted input beat it computes the expected block from its own
// copy of the key, with the schedule, the Feistel rounds and the reduced
// Ascon rounds. It compares each accepted output beat with the oldest
// expected block and counts every failure.
// ----------------------------------------------------------------------------
module tfbc_checker
#(
    parameter int FEISTEL_ROUNDS = tfbc_pkg::FEISTEL_ROUNDS_DEF,
    parameter int PERM_ROUNDS    = tfbc_pkg::PERM_ROUNDS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tfbc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfbc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                           in_valid,
    input  logic                           in_stall,
    input  logic                           op,
    input  logic [63:0]                    data_hi,
    input  logic [63:0]                    data_lo,
    input  logic [63:0]                    tweak_hi,
    input  logic [31:0]                    tweak_lo,
    input  logic                           out_valid,
    input  logic                           out_stall,
    input  logic [63:0]                    out_hi,
    input  logic [63:0]                    out_lo,
    output int                             fail_count,
    output int                             blocks_pending
);

    localparam int ROUNDS_N = (FEISTEL_ROUNDS < 1) ? 1 :
                              ((FEISTEL_ROUNDS > 64) ? 64 : FEISTEL_ROUNDS);
    localparam int PERM_N   = (PERM_ROUNDS < 1) ? 1 :
                              ((PERM_ROUNDS > tfbc_pkg::ASCON_ROUNDS) ?
                               tfbc_pkg::ASCON_ROUNDS : PERM_ROUNDS);

    typedef struct packed {
        logic [63:0] hi;
        logic [63:0] lo;
    } cipher_block_t;

    cipher_block_t expected_blocks[$];
    logic [127:0]  cipher_key;
    int            errs = 0;

    function automatic logic [63:0] ror64(logic [63:0] x, int n);
        return (x >> n) | (x << (64 - n));
    endfunction

    function automatic logic [127:0] key_times_x(logic [127:0] k);
        return {k[126:0], 1'b0} ^ (k[127] ? {120'd0, tfbc_pkg::GF_POLY} : 128'd0);
    endfunction

    // round function: word x0 of the state after the last PERM_N Ascon rounds
    function automatic logic [63:0] feistel_mix(logic [63:0] right, logic [127:0] rkey,
                                                logic [63:0] th, logic [31:0] tl,
                                                int ridx);
        logic [63:0] a0, a1, a2, a3, a4;
        logic [63:0] b0, b1, b2, b3, b4;
        logic [3:0]  kb;
        a0 = right;
        a1 = rkey[127:64];
        a2 = rkey[63:0];
        a3 = th;
        a4 = {tl, tfbc_pkg::ROUND_CONST[ridx & 63]};
        for (int k = tfbc_pkg::ASCON_ROUNDS - PERM_N; k < tfbc_pkg::ASCON_ROUNDS; k++)
        begin
            kb = 4'(k);
            a2 = a2 ^ {56'd0, ~kb, kb};
            a0 = a0 ^ a4;
            a4 = a4 ^ a3;
            a2 = a2 ^ a1;
            b0 = ~a0 & a1;
            b1 = ~a1 & a2;
            b2 = ~a2 & a3;
            b3 = ~a3 & a4;
            b4 = ~a4 & a0;
            a0 = a0 ^ b1;
            a1 = a1 ^ b2;
            a2 = a2 ^ b3;
            a3 = a3 ^ b4;
            a4 = a4 ^ b0;
            a1 = a1 ^ a0;
            a0 = a0 ^ a4;
            a3 = a3 ^ a2;
            a2 = ~a2;
            a0 = a0 ^ ror64(a0, 19) ^ ror64(a0, 28);
            a1 = a1 ^ ror64(a1, 61) ^ ror64(a1, 39);
            a2 = a2 ^ ror64(a2, 1) ^ ror64(a2, 6);
            a3 = a3 ^ ror64(a3, 10) ^ ror64(a3, 17);
            a4 = a4 ^ ror64(a4, 7) ^ ror64(a4, 41);
        end
        return a0;
    endfunction

    function automatic cipher_block_t cipher_block(logic decrypt, logic [63:0] hi,
                                                   logic [63:0] lo, logic [63:0] th,
                                                   logic [31:0] tl);
        logic [127:0]  sched [64];
        logic [63:0]   left;
        logic [63:0]   right;
        logic [63:0]   mixed;
        int            idx;
        cipher_block_t res;
        sched[0] = cipher_key;
        for (int i = 1; i < ROUNDS_N; i++)
        begin
            sched[i] = key_times_x(sched[i-1]);
        end
        left  = hi;
        right = lo;
        for (int i = 0; i < ROUNDS_N; i++)
        begin
            idx   = decrypt ? (ROUNDS_N - 1 - i) : i;
            mixed = left ^ feistel_mix(right, sched[idx], th, tl, idx);
            left  = right;
            right = mixed;
        end
        res.hi = right;
        res.lo = left;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        cipher_block_t want;
        if (!rst_n)
        begin
            cipher_key = '0;
            expected_blocks.delete();
            blocks_pending <= 0;
            fail_count     <= errs;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    tfbc_pkg::REG_KEY_HI: cipher_key[127:64] = cfg_data;
                    tfbc_pkg::REG_KEY_LO: cipher_key[63:0]   = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                expected_blocks.push_back(cipher_block(op, data_hi, data_lo,
                                                       tweak_hi, tweak_lo));
            end
            if (out_valid && !out_stall)
            begin
                if (expected_blocks.size() == 0)
                begin
                    $error("output beat with no block expected: out_hi %h out_lo %h",
                           out_hi, out_lo);
                    errs++;
                end
                else
                begin
                    want = expected_blocks.pop_front();
                    if (out_hi !== want.hi)
                    begin
                        $error("out_hi mismatch: expected %h, actual %h", want.hi, out_hi);
                        errs++;
                    end
                    if (out_lo !== want.lo)
                    begin
                        $error("out_lo mismatch: expected %h, actual %h", want.lo, out_lo);
                        errs++;
                    end
                end
            end
            blocks_pending <= expected_blocks.size();
            fail_count     <= errs;
        end
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Stimulus for the tweakable Feistel block cipher unit. A short directed set
// covers the field extremes, both directions, the null tweak, a key that
// folds in the reduction polynomial and writes to unused register indexes.
// Random phases then run under several keys, with random gaps on the input,
// random output stalls and one long output hold-off. Checking is done by
// tfbc_checker.
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [tfbc_pkg::CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [tfbc_pkg::CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
    localparam logic                 OP_ENCRYPT  = 1'b0;
    localparam logic                 OP_DECRYPT  = 1'b1;
    localparam int                   PHASES      = 8;
    localparam int                   PHASE_BLOCKS = 180;
    localparam int                   HOLD_AT     = 400;
    localparam int                   HOLD_CYCLES = 500;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [tfbc_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [tfbc_pkg::CFG_W-1:0]     cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic               op;
    logic [63:0]        data_hi;
    logic [63:0]        data_lo;
    logic [63:0]        tweak_hi;
    logic [31:0]        tweak_lo;
    logic               out_valid;
    logic               out_stall;
    logic [63:0]        out_hi;
    logic [63:0]        out_lo;
    int                 fail_count;
    int                 blocks_pending;

    int                 sent_blocks = 0;
    int                 enc_blocks = 0;
    int                 dec_blocks = 0;
    int                 key_settings = 1;
    bit                 no_gaps = 0;
    bit                 held = 0;

    tweakable_feistel_block_cipher_unit dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .data_hi   (data_hi),
        .data_lo   (data_lo),
        .tweak_hi  (tweak_hi),
        .tweak_lo  (tweak_lo),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_hi    (out_hi),
        .out_lo    (out_lo)
    );

    tfbc_checker u_checker
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .data_hi        (data_hi),
        .data_lo        (data_lo),
        .tweak_hi       (tweak_hi),
        .tweak_lo       (tweak_lo),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_hi         (out_hi),
        .out_lo         (out_lo),
        .fail_count     (fail_count),
        .blocks_pending (blocks_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_500_000;
        $display("[tweakable_feistel_block_cipher_unit] ERROR");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        logic [63:0] w;
        w = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: w = '0;
            1: w = '1;
            2: w = 64'd1 << $urandom_range(0, 63);
            3: w = ~(64'd1 << $urandom_range(0, 63));
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_block(logic dir, logic [63:0] hi, logic [63:0] lo,
                              logic [63:0] th, logic [31:0] tl);
        int pick;
        int gap;
        in_valid <= 1'b1;
        op       <= dir;
        data_hi  <= hi;
        data_lo  <= lo;
        tweak_hi <= th;
        tweak_lo <= tl;
        do
            @(posedge clk);
        while (in_stall);
        sent_blocks++;
        if (dir == OP_DECRYPT)
            dec_blocks++;
        else
            enc_blocks++;
        pick = $urandom_range(0, 99);
        if (no_gaps || pick < 60)
            gap = 0;
        else if (pick < 90)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 80);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (blocks_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [tfbc_pkg::CFG_IDX_W-1:0] idx,
                             logic [tfbc_pkg::CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        // key writes trigger a schedule sweep
        repeat (tfbc_pkg::FEISTEL_ROUNDS_DEF + 2) @(posedge clk);
    endtask

    task automatic set_key(logic [63:0] hi, logic [63:0] lo);
        drain();
        write_reg(tfbc_pkg::REG_KEY_HI, hi);
        write_reg(tfbc_pkg::REG_KEY_LO, lo);
        key_settings++;
    endtask

    task automatic random_block();
        logic [63:0] th;
        logic [31:0] tl;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 2)
        begin
            th = '0;
            tl = '0;
        end
        else if (pick == 2)
        begin
            th = '1;
            tl = '1;
        end
        else
        begin
            th = rand_word();
            tl = $urandom;
        end
        send_block(1'($urandom_range(0, 1)), rand_word(), rand_word(), th, tl);
    endtask

    // output side: random stall runs, one long hold-off while input keeps coming
    initial
    begin
        int  run_left;
        int  pick;
        logic stall_val;
        run_left  = 0;
        stall_val = 1'b0;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (run_left == 0)
            begin
                pick = $urandom_range(0, 99);
                if (!held && sent_blocks >= HOLD_AT)
                begin
                    held      = 1;
                    stall_val = 1'b1;
                    run_left  = HOLD_CYCLES;
                end
                else if (pick < 45)
                begin
                    stall_val = 1'b0;
                    run_left  = $urandom_range(1, 40);
                end
                else if (pick < 85)
                begin
                    stall_val = 1'b1;
                    run_left  = $urandom_range(1, 3);
                end
                else
                begin
                    stall_val = 1'b1;
                    run_left  = $urandom_range(10, 120);
                end
            end
            out_stall <= stall_val;
            run_left--;
        end
    end

    initial
    begin
        logic [63:0] r0;
        logic [63:0] r1;
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= tfbc_pkg::REG_KEY_HI;
        cfg_data  <= '0;
        in_valid  <= 1'b0;
        op        <= OP_ENCRYPT;
        data_hi   <= '0;
        data_lo   <= '0;
        tweak_hi  <= '0;
        tweak_lo  <= '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // all-zero key after reset; null tweak and field extremes
        send_block(OP_ENCRYPT, '0, '0, '0, '0);
        send_block(OP_DECRYPT, '0, '0, '0, '0);
        send_block(OP_ENCRYPT, '1, '1, '1, '1);
        send_block(OP_DECRYPT, '1, '1, '1, '1);
        send_block(OP_ENCRYPT, '1, '0, '1, '0);
        send_block(OP_DECRYPT, '0, '1, '0, '1);

        set_key('1, '1);
        send_block(OP_ENCRYPT, '0, '0, '0, '0);
        send_block(OP_DECRYPT, '0, '0, '0, '0);
        send_block(OP_ENCRYPT, '1, '1, '1, '1);
        send_block(OP_DECRYPT, '1, '1, '1, '1);

        // top key bit set: schedule folds in the polynomial
        set_key(64'h8000_0000_0000_0000, '0);
        r0 = rand_word();
        r1 = rand_word();
        send_block(OP_ENCRYPT, r0, r1, rand_word(), $urandom);
        send_block(OP_DECRYPT, r0, r1, rand_word(), $urandom);

        // unused indexes leave the key alone
        drain();
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '1);
        send_block(OP_ENCRYPT, r1, r0, '0, '0);
        send_block(OP_DECRYPT, r1, r0, '1, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                2: set_key('1, '1);
                3: set_key('0, '1);
                5: set_key('0, '0);
                6: set_key({1'b1, 63'($urandom_range(0, 1) ? rand_word() : '0)}, rand_word());
                default: set_key(rand_word(), rand_word());
            endcase
            if (p % 2 == 1)
            begin
                write_reg(p % 4 == 1 ? REG_SPARE_A : REG_SPARE_B, rand_word());
            end
            no_gaps = (p % 3 == 0);
            for (int n = 0; n < PHASE_BLOCKS; n++)
                random_block();
            no_gaps = 0;
        end

        drain();
        repeat (60) @(posedge clk);
        $display("Covered %0d blocks (%0d encrypt, %0d decrypt) under %0d key settings,",
                 sent_blocks, enc_blocks, dec_blocks, key_settings);
        $display("with input gaps, output stalls and one %0d-cycle output hold-off.",
                 HOLD_CYCLES);
        if (fail_count == 0 && blocks_pending == 0)
            $display("[tweakable_feistel_block_cipher_unit] OK");
        else
            $display("[tweakable_feistel_block_cipher_unit] ERROR");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+src
src/tfbc_pkg.sv
src/tfbc_datapath.sv
src/tfbc_ctrl.sv
src/tweakable_feistel_block_cipher_unit.sv
dv/tfbc_checker.sv
dv/testbench.sv
